// ===== hw/rtl/tad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient amount detector package
// Shared widths, register indexes and the controller-to-datapath command types.
// ----------------------------------------------------------------------------
package tad_pkg;

    localparam int SampleBits = 24;
    localparam int CoefBits   = 24;
    localparam int GuardBits  = 24;
    localparam int CtrlFrac   = 23;
    localparam int LevelBits  = 48;
    localparam int RegBits    = 24;
    localparam int NumRegs    = 8;
    localparam int IdxBits    = 3;

    // Register indexes on the configuration port.
    localparam logic [IdxBits-1:0] REG_FAST_ATTACK   = 3'd0;
    localparam logic [IdxBits-1:0] REG_FAST_RELEASE  = 3'd1;
    localparam logic [IdxBits-1:0] REG_SLOW_ATTACK   = 3'd2;
    localparam logic [IdxBits-1:0] REG_SLOW_RELEASE  = 3'd3;
    localparam logic [IdxBits-1:0] REG_SMOOTH_ATTACK = 3'd4;
    localparam logic [IdxBits-1:0] REG_SMOOTH_RELEASE = 3'd5;
    localparam logic [IdxBits-1:0] REG_GATE_FLOOR    = 3'd6;
    localparam logic [IdxBits-1:0] REG_NORM_MIN      = 3'd7;

    // Follower selection.
    localparam logic [1:0] SEL_FAST   = 2'd0;
    localparam logic [1:0] SEL_SLOW   = 2'd1;
    localparam logic [1:0] SEL_SMOOTH = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIFF,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_UPDATE,
        OP_DIV_SETUP,
        OP_DIV_STEP,
        OP_OUTPUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] sel;
    } t_dp_cmd;

    typedef struct packed {
        logic div_resolved;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/transient_amount_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient amount detector
// Fast and slow peak followers, normalized difference and an output smoother.
// ----------------------------------------------------------------------------
// One item at a time: a sample is taken only in the idle state, after the previous
// result has entered the output register. Each item runs the shared multiplier
// sequence (three followers: diff, low, high, update each) and the 23-step restoring
// divider; when the target needs no divide, the divider steps are skipped.
// Reset (synchronous, active low) clears all followers and loads default registers.
module transient_amount_detector_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [23:0] audio_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [23:0] transient_amount
);
    import tad_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    tad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tad_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== hw/rtl/tad_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient amount detector controller
// Sequences the three follower updates and the restoring divide for one item.
// ----------------------------------------------------------------------------
module tad_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tad_pkg::t_dp_status i_status,
    output tad_pkg::t_dp_cmd    o_cmd
);
    import tad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIFF, S_MLO, S_MHI, S_UPD, S_DSET, S_DSTEP, S_OUT
    } t_state;

    t_state     r_state;
    logic [1:0] r_sel;
    logic [4:0] r_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    // Command decode from the current state.
    always_comb begin
        o_cmd.sel = r_sel;
        case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_DIFF:  o_cmd.op = OP_DIFF;
            S_MLO:   o_cmd.op = OP_MUL_LO;
            S_MHI:   o_cmd.op = OP_MUL_HI;
            S_UPD:   o_cmd.op = OP_UPDATE;
            S_DSET:  o_cmd.op = OP_DIV_SETUP;
            S_DSTEP: o_cmd.op = OP_DIV_STEP;
            S_OUT:   o_cmd.op = i_status.out_free ? OP_OUTPUT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    // State and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_FAST;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sel   <= SEL_FAST;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: r_state <= S_MLO;
                S_MLO:  r_state <= S_MHI;
                S_MHI:  r_state <= S_UPD;
                S_UPD: begin
                    if (r_sel == SEL_FAST) begin
                        r_sel   <= SEL_SLOW;
                        r_state <= S_DIFF;
                    end else if (r_sel == SEL_SLOW) begin
                        r_state <= S_DSET;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_DSET: begin
                    r_cnt <= '0;
                    if (i_status.div_resolved) begin
                        r_sel   <= SEL_SMOOTH;
                        r_state <= S_DIFF;
                    end else begin
                        r_state <= S_DSTEP;
                    end
                end
                S_DSTEP: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(CtrlFrac - 1)) begin
                        r_sel   <= SEL_SMOOTH;
                        r_state <= S_DIFF;
                    end
                end
                S_OUT: begin
                    if (i_status.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/tad_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient amount detector datapath
// Levels, registers, one shared 24x24 multiplier, divider and output register.
// ----------------------------------------------------------------------------
module tad_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tad_pkg::IdxBits-1:0]       i_cfg_addr,
    input  logic [tad_pkg::RegBits-1:0]       i_cfg_wdata,
    input  logic signed [tad_pkg::SampleBits-1:0] i_sample,
    input  tad_pkg::t_dp_cmd                  i_cmd,
    output tad_pkg::t_dp_status               o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [23:0]                       o_out_data
);
    import tad_pkg::*;

    logic [RegBits-1:0]   r_regs [NumRegs];
    logic [LevelBits-1:0] r_fast, r_slow, r_smooth, r_goal;
    logic [LevelBits-1:0] r_diff, r_step, r_divisor;
    logic [LevelBits:0]   r_rem;
    logic [CoefBits-1:0]  r_coef;
    logic                 r_up;
    logic [23:0]          r_target;
    logic                 r_out_valid;
    logic [23:0]          r_out_data;

    logic [LevelBits-1:0] w_level, w_goal, w_floor_lv, w_norm_lv, w_divisor;
    logic [CoefBits-1:0]  w_rise, w_fall;
    logic [SampleBits-1:0] w_mag;
    logic [2*CoefBits-1:0] w_prod;
    logic [LevelBits:0]   w_shift;
    logic                 w_ge;
    logic                 w_gate_open;
    logic                 w_full;
    logic                 w_resolved;

    // Current follower level, goal and coefficients.
    always_comb begin
        case (i_cmd.sel)
            SEL_FAST: begin
                w_level = r_fast;   w_goal = r_goal;
                w_rise = r_regs[REG_FAST_ATTACK]; w_fall = r_regs[REG_FAST_RELEASE];
            end
            SEL_SLOW: begin
                w_level = r_slow;   w_goal = r_goal;
                w_rise = r_regs[REG_SLOW_ATTACK]; w_fall = r_regs[REG_SLOW_RELEASE];
            end
            default: begin
                w_level = r_smooth; w_goal = {r_target, {GuardBits{1'b0}}};
                w_rise = r_regs[REG_SMOOTH_ATTACK]; w_fall = r_regs[REG_SMOOTH_RELEASE];
            end
        endcase
    end

    // Magnitude of the sample; the most negative code maps to exactly 1.0.
    assign w_mag = i_sample[SampleBits-1] ? (~i_sample + 1'b1) : i_sample;

    // Shared multiplier: low half then high half of the level difference.
    assign w_prod = (i_cmd.op == OP_MUL_HI) ? (r_diff[LevelBits-1:CoefBits] * r_coef)
                                            : (r_diff[CoefBits-1:0] * r_coef);

    assign w_floor_lv = {r_regs[REG_GATE_FLOOR], {GuardBits{1'b0}}};
    assign w_norm_lv  = {r_regs[REG_NORM_MIN], {GuardBits{1'b0}}};
    assign w_divisor  = (r_fast > w_norm_lv) ? r_fast : w_norm_lv;

    // The target is settled without a divide when gated off or at full scale.
    assign w_gate_open = (r_fast > w_floor_lv) && (r_fast > r_slow);
    assign w_full      = ((r_fast - r_slow) >= w_divisor);
    assign w_resolved  = !w_gate_open || w_full;

    // One restoring divide step.
    assign w_shift = {r_rem[LevelBits-1:0], 1'b0};
    assign w_ge    = (w_shift >= {1'b0, r_divisor});

    assign o_status.div_resolved = w_resolved;
    assign o_status.out_free     = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[REG_FAST_ATTACK]    <= 24'd231407;
            r_regs[REG_FAST_RELEASE]   <= 24'd9983;
            r_regs[REG_SLOW_ATTACK]    <= 24'd17467;
            r_regs[REG_SLOW_RELEASE]   <= 24'd1398;
            r_regs[REG_SMOOTH_ATTACK]  <= 24'd173855;
            r_regs[REG_SMOOTH_RELEASE] <= 24'd6354;
            r_regs[REG_GATE_FLOOR]     <= 24'd16777;
            r_regs[REG_NORM_MIN]       <= 24'd209715;
        end else if (i_cfg_we) begin
            r_regs[i_cfg_addr] <= i_cfg_wdata;
        end
    end

    // Follower state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast      <= '0;
            r_slow      <= '0;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_UPDATE) begin
                case (i_cmd.sel)
                    SEL_FAST: r_fast   <= r_up ? r_fast + r_step : r_fast - r_step;
                    SEL_SLOW: r_slow   <= r_up ? r_slow + r_step : r_slow - r_step;
                    default:  r_smooth <= r_up ? r_smooth + r_step : r_smooth - r_step;
                endcase
            end
            if (i_cmd.op == OP_OUTPUT) r_out_valid <= 1'b1;
            else if (i_out_ready)      r_out_valid <= 1'b0;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: r_goal <= {w_mag, {GuardBits{1'b0}}};
            OP_DIFF: begin
                r_up   <= (w_goal > w_level);
                r_diff <= (w_goal > w_level) ? w_goal - w_level : w_level - w_goal;
                r_coef <= (w_goal > w_level) ? w_rise : w_fall;
            end
            OP_MUL_LO: r_step <= {{CoefBits{1'b0}}, w_prod[2*CoefBits-1:CoefBits]};
            OP_MUL_HI: r_step <= r_step + w_prod;
            OP_DIV_SETUP: begin
                r_divisor <= w_divisor;
                r_rem     <= {1'b0, r_fast - r_slow};
                if (w_gate_open && w_full) begin
                    r_target <= 24'(1) << CtrlFrac;
                end else begin
                    r_target <= '0;
                end
            end
            OP_DIV_STEP: begin
                r_rem    <= w_ge ? w_shift - {1'b0, r_divisor} : w_shift;
                r_target <= {r_target[22:0], w_ge};
            end
            OP_OUTPUT: r_out_data <= r_smooth[LevelBits-1:GuardBits];
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/tad_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient amount detector checker
// Port-level properties of the detector, bound to the top level.
// ----------------------------------------------------------------------------
module tad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    // A stalled result item holds its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // The amount never exceeds 1.0.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 24'd8388608)
        else $error("result item above 1.0");

    // One item at a time: no new item is taken right after an accept.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // No result item shows in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result item after reset");

endmodule

bind transient_amount_detector_unit tad_checker u_tad_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/tb_transient_amount_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient amount checker
// Watches the sample and amount streams and the register port, keeps its own
// copy of the three followers and the registers, predicts the amount for each
// accepted sample and compares it with the next amount that leaves the block.
// ----------------------------------------------------------------------------
module tb_transient_amount_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [23:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [23:0] i_in_data,     // [23:0] audio_in
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,    // [23:0] transient_amount
    output int          o_fail_count,
    output int          o_pending,
    output int          o_amount_count
);
    import tad_pkg::*;

    logic [23:0] regs [NumRegs];
    logic [63:0] fast_env;
    logic [63:0] slow_env;
    logic [63:0] smooth_env;
    logic [23:0] amount_queue [$];

    // floor(a * c / 2^24) with enough width to hold the product.
    function automatic logic [63:0] coef_scale(input logic [63:0] a, input logic [23:0] c);
        logic [95:0] prod;
        prod = a * c;
        return prod[87:24];
    endfunction

    function automatic logic [63:0] track(input logic [63:0] lvl, input logic [63:0] goal,
                                          input logic [23:0] rise, input logic [23:0] fall);
        if (goal > lvl) return lvl + coef_scale(goal - lvl, rise);
        return lvl - coef_scale(lvl - goal, fall);
    endfunction

    // Advance the followers by one sample and return the expected amount.
    function automatic logic [23:0] next_amount(input logic [23:0] sample);
        logic [63:0] mag, goal, floor_lv, norm_lv, divisor, diff, rem, target;
        logic [23:0] mag24;
        // Magnitude in 24 bits; the most negative code gives exactly 1.0.
        mag24 = sample[23] ? (~sample + 24'd1) : sample;
        mag = 64'(mag24);
        goal = mag << GuardBits;
        fast_env = track(fast_env, goal, regs[REG_FAST_ATTACK], regs[REG_FAST_RELEASE]);
        slow_env = track(slow_env, goal, regs[REG_SLOW_ATTACK], regs[REG_SLOW_RELEASE]);
        floor_lv = 64'(regs[REG_GATE_FLOOR]) << GuardBits;
        norm_lv = 64'(regs[REG_NORM_MIN]) << GuardBits;
        divisor = (fast_env > norm_lv) ? fast_env : norm_lv;
        target = 0;
        if (fast_env > floor_lv && fast_env > slow_env) begin
            diff = fast_env - slow_env;
            if (diff >= divisor) begin
                target = 64'h800000;
            end else begin
                rem = diff;
                for (int k = 0; k < CtrlFrac; k++) begin
                    rem = rem << 1;
                    target = target << 1;
                    if (rem >= divisor) begin
                        rem = rem - divisor;
                        target[0] = 1'b1;
                    end
                end
            end
        end
        smooth_env = track(smooth_env, target << GuardBits,
                           regs[REG_SMOOTH_ATTACK], regs[REG_SMOOTH_RELEASE]);
        return smooth_env[47:24];
    endfunction

    assign o_pending = amount_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs[REG_FAST_ATTACK]    <= 24'd231407;
            regs[REG_FAST_RELEASE]   <= 24'd9983;
            regs[REG_SLOW_ATTACK]    <= 24'd17467;
            regs[REG_SLOW_RELEASE]   <= 24'd1398;
            regs[REG_SMOOTH_ATTACK]  <= 24'd173855;
            regs[REG_SMOOTH_RELEASE] <= 24'd6354;
            regs[REG_GATE_FLOOR]     <= 24'd16777;
            regs[REG_NORM_MIN]       <= 24'd209715;
            fast_env = 0;
            slow_env = 0;
            smooth_env = 0;
            amount_queue.delete();
            o_fail_count <= 0;
            o_amount_count <= 0;
        end else begin
            if (i_cfg_we) regs[i_cfg_addr] <= i_cfg_wdata;
            if (i_in_valid && i_in_ready) amount_queue.push_back(next_amount(i_in_data));
            // Compare each delivered amount with the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                o_amount_count <= o_amount_count + 1;
                if (amount_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: amount %0d with no sample pending", $realtime, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (amount_queue[0] !== i_out_data) begin
                        if (o_fail_count < 10)
                            $display("%0t: amount mismatch, expected %0d, got %0d",
                                     $realtime, amount_queue[0], i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(amount_queue.pop_front());
                end
            end
        end
    end

endmodule

// ===== tb/tb_transient_amount_detector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transient amount detector testbench
// Drives samples through several register settings with random gaps and
// back-pressure; the checker predicts and compares every amount.
// ----------------------------------------------------------------------------
module tb_transient_amount_detector_unit;
    import tad_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int RandomItems = 620;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [23:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    int          fail_count;
    int          pending;
    int          amount_count;
    int          cycle_count;
    int          sample_count;
    bit          sink_hold;
    bit          sink_gaps;

    transient_amount_detector_unit dut (.*);

    tb_transient_amount_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_amount_count(amount_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("tb_transient_amount_detector_unit: FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when requested.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge i_clk);
                sink_hold = 1'b0;
            end
            stall = sink_gaps ? $urandom_range(0, 13) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Valid stays up after an accept until the next gap or drain; the block is
    // busy after an accept until its result is registered, so the held item is never taken twice.
    task automatic send_sample(input logic [23:0] sample, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sample;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sample_count++;
    endtask

    // Wait for all amounts, then let a possible trailing computation finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly bursts with decays, some full-scale and noise samples.
    function automatic logic [23:0] random_sample(input int phase);
        case ($urandom_range(0, 9))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'($urandom);
            3, 4: return 24'($signed($urandom_range(0, 200)) - 100);
            default: return (phase % 40 < 6) ? 24'($urandom) : 24'($urandom_range(0, 4000));
        endcase
    endfunction

    initial begin
        logic [23:0] directed [] = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'h800001,
            24'h000001, 24'hFFFFFF, 24'h400000, 24'hC00000, 24'h000000, 24'h000000,
            24'h555555, 24'hAAAAAA, 24'h7FFFFF, 24'h7FFFFF, 24'h000000, 24'h000010};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_FAST_ATTACK;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        sink_hold = 1'b0;
        sink_gaps = 1'b1;
        cycle_count = 0;
        sample_count = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed samples at reset defaults, including equal level and magnitude.
        foreach (directed[i]) send_sample(directed[i], 1'b0);
        drain();

        // Fast/smooth full speed, slow frozen, zero floor, min normaliser.
        write_reg(REG_FAST_ATTACK, 24'hFFFFFF);
        write_reg(REG_FAST_RELEASE, 24'hFFFFFF);
        write_reg(REG_SLOW_ATTACK, 24'h000000);
        write_reg(REG_SLOW_RELEASE, 24'h000000);
        write_reg(REG_SMOOTH_ATTACK, 24'hFFFFFF);
        write_reg(REG_SMOOTH_RELEASE, 24'hFFFFFF);
        write_reg(REG_GATE_FLOOR, 24'd0);
        write_reg(REG_NORM_MIN, 24'd1);
        foreach (directed[i]) if (i < 8) send_sample(directed[i], 1'b0);

        // Long receiver hold-off while samples keep coming.
        sink_hold = 1'b1;
        for (int i = 0; i < 12; i++) send_sample(random_sample(i), 1'b0);
        drain();

        // Random phases, each with fresh register settings.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_FAST_ATTACK, (ph == 1) ? 24'hFFFFFF : 24'($urandom_range(0, 2000000)));
            write_reg(REG_FAST_RELEASE, 24'($urandom_range(0, 300000)));
            write_reg(REG_SLOW_ATTACK, 24'($urandom_range(0, 200000)));
            write_reg(REG_SLOW_RELEASE, (ph == 2) ? 24'h000000 : 24'($urandom_range(0, 50000)));
            write_reg(REG_SMOOTH_ATTACK, (ph == 3) ? 24'hFFFFFF : 24'($urandom));
            write_reg(REG_SMOOTH_RELEASE, 24'($urandom_range(0, 500000)));
            write_reg(REG_GATE_FLOOR, (ph == 4) ? 24'h800000 : 24'($urandom_range(0, 40000)));
            write_reg(REG_NORM_MIN, (ph == 5) ? 24'h800000 : 24'($urandom_range(1, 2000000)));
            sink_gaps = (ph != 2);
            for (int i = 0; i < RandomItems / 6; i++)
                send_sample(random_sample(i), ph != 2 && (i % 50) < 40);
            // Sender pauses until every amount is back.
            drain();
        end

        $display("Ran %0d samples through eight register settings; %0d amounts checked.",
                 sample_count, amount_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_transient_amount_detector_unit: PASS");
        end else begin
            $display("tb_transient_amount_detector_unit: FAIL");
        end
        $finish;
    end

endmodule
